@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bsd_pkg.sv @@
// Shared types and constants of the BMP stream decoder.
package bsd_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_SIG    = 3'd1;
  localparam logic [2:0] ERR_DIB    = 3'd2;
  localparam logic [2:0] ERR_WIDTH  = 3'd3;
  localparam logic [2:0] ERR_HEIGHT = 3'd4;
  localparam logic [2:0] ERR_FORMAT = 3'd5;
  localparam logic [2:0] ERR_OFFSET = 3'd6;
  localparam logic [2:0] ERR_TRUNC  = 3'd7;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] pixel_bgra;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } result_t;

endpackage

@@ src/bsd_in_stage.sv @@
// Input register stage: holds one byte beat for the decode core.
module bsd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bsd_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_take,
  output bsd_pkg::item_t item
);
  import bsd_pkg::*;

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ src/bsd_core.sv @@
// Decode core: header capture and checks, offset skip, pixel assembly.
module bsd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  bsd_pkg::item_t   item,
  output logic             item_take,
  input  logic             res_ready,
  output logic             res_valid,
  output bsd_pkg::result_t res
);
  import bsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [5:0]  POS_SIG1   = 6'd1;
  localparam logic [5:0]  POS_DIB    = 6'd17;
  localparam logic [5:0]  POS_WIDTH  = 6'd21;
  localparam logic [5:0]  POS_HEIGHT = 6'd25;
  localparam logic [5:0]  POS_FMT    = 6'd33;
  localparam logic [5:0]  POS_LAST   = 6'd53;
  localparam logic [31:0] OFF_MIN    = 32'd54;

  phase_t             phase, phase_next;
  logic [31:0]        pos, pos_next;
  logic [31:0]        pix_off, pix_off_next;
  logic [31:0]        dib, dib_next;
  logic [31:0]        width, width_next;
  logic [31:0]        height, height_next;
  logic [15:0]        bpp, bpp_next;
  logic [31:0]        comp, comp_next;
  logic [DIM_W-1:0]   col, col_next;
  logic [DIM_W-1:0]   row, row_next;
  logic [DIM_W-1:0]   habs, habs_next;
  logic               bottom, bottom_next;
  logic [1:0]         bip, bip_next;
  logic [23:0]        gather, gather_next;
  logic [1:0]         pad, pad_next;

  logic [7:0]         b;
  logic [5:0]         hpos;
  logic [1:0]         lane;
  logic [31:0]        habs_full;
  logic               bpp32;
  logic [1:0]         last;
  logic [2:0]         err;
  logic               have_pix, complete, row_end, emit;
  logic [DIM_W-1:0]   pcol, prow;
  logic [31:0]        pval;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic [1:0]         pad_dec;

  assign item_take = item_valid && res_ready;
  assign b         = item.byte_in;
  assign hpos      = pos[5:0];
  assign lane      = hpos[1:0] - 2'd2;
  assign bpp32     = (bpp == 16'd32);
  assign last      = bpp32 ? 2'd3 : 2'd2;
  assign col_inc   = col + 1'b1;
  assign row_inc   = row + 1'b1;
  assign pad_dec   = pad - 2'd1;

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    pix_off_next = pix_off;
    dib_next     = dib;
    width_next   = width;
    height_next  = height;
    bpp_next     = bpp;
    comp_next    = comp;
    col_next     = col;
    row_next     = row;
    habs_next    = habs;
    bottom_next  = bottom;
    bip_next     = bip;
    gather_next  = gather;
    pad_next     = pad;
    err          = ERR_NONE;
    have_pix     = 1'b0;
    complete     = 1'b0;
    row_end      = 1'b0;
    pcol         = '0;
    prow         = '0;
    pval         = '0;
    habs_full    = height_next[31] ? (32'd0 - height_next) : height_next;
    emit         = 1'b0;
    res          = '0;

    case (phase)
      PH_HEADER: begin
        if (hpos >= 6'd10 && hpos <= 6'd13) pix_off_next[{lane, 3'b000} +: 8] = b;
        if (hpos >= 6'd14 && hpos <= 6'd17) dib_next[{lane, 3'b000} +: 8] = b;
        if (hpos >= 6'd18 && hpos <= 6'd21) width_next[{lane, 3'b000} +: 8] = b;
        if (hpos >= 6'd22 && hpos <= 6'd25) height_next[{lane, 3'b000} +: 8] = b;
        if (hpos >= 6'd28 && hpos <= 6'd29) bpp_next[{hpos[0], 3'b000} +: 8] = b;
        if (hpos >= 6'd30 && hpos <= 6'd33) comp_next[{lane, 3'b000} +: 8] = b;
        habs_full = height_next[31] ? (32'd0 - height_next) : height_next;
        if (hpos == 6'd0 && b != SIG_B) err = ERR_SIG;
        if (hpos == POS_SIG1 && b != SIG_M) err = ERR_SIG;
        if (hpos == POS_DIB && dib_next != 32'd40 && dib_next != 32'd108
            && dib_next != 32'd124) err = ERR_DIB;
        if (hpos == POS_WIDTH && (width_next == 32'd0 || width_next > 32'(MAX_DIM)))
          err = ERR_WIDTH;
        if (hpos == POS_HEIGHT && (habs_full == 32'd0 || habs_full > 32'(MAX_DIM)))
          err = ERR_HEIGHT;
        if (hpos == POS_HEIGHT) begin
          habs_next   = habs_full[DIM_W-1:0];
          bottom_next = !height_next[31];
        end
        if (hpos == POS_FMT && ((bpp_next != 16'd24 && bpp_next != 16'd32)
            || (comp_next != 32'd0 && comp_next != 32'd3))) err = ERR_FORMAT;
        if (hpos == POS_LAST && pix_off < OFF_MIN) err = ERR_OFFSET;
        pos_next = pos + 32'd1;
        if (hpos == POS_LAST && err == ERR_NONE) begin
          phase_next = (pix_off == OFF_MIN) ? PH_PIXELS : PH_SKIP;
        end
      end
      PH_SKIP: begin
        pos_next = pos + 32'd1;
        if (pos_next >= pix_off) phase_next = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (bip < last) begin
          gather_next[{bip, 3'b000} +: 8] = b;
          bip_next = bip + 2'd1;
        end else begin
          pval        = bpp32 ? {b, gather} : {8'hFF, b, gather[15:0]};
          pcol        = col;
          prow        = bottom ? (habs - 1'b1 - row) : row;
          have_pix    = 1'b1;
          bip_next    = 2'd0;
          gather_next = '0;
          col_next    = col_inc;
          if (col_inc >= width[DIM_W-1:0]) begin
            col_next = '0;
            if (!bpp32 && width[1:0] != 2'd0) begin
              pad_next   = width[1:0];
              phase_next = PH_PAD;
            end else begin
              row_end = 1'b1;
            end
          end
        end
      end
      PH_PAD: begin
        pad_next = pad_dec;
        if (pad_dec == 2'd0) row_end = 1'b1;
      end
      default: begin
      end
    endcase

    if (row_end) begin
      row_next = row_inc;
      if (row_inc >= habs) begin
        phase_next = PH_DONE;
        complete   = 1'b1;
      end else begin
        phase_next = PH_PIXELS;
      end
    end

    if (err != ERR_NONE) begin
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = err;
      phase_next     = PH_ERROR;
    end else if (item.end_of_file && phase != PH_DONE && phase != PH_ERROR && !complete) begin
      emit           = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_TRUNC;
      if (phase_next != PH_HEADER) begin
        res.image_width  = width[12:0];
        res.image_height = 13'(habs);
      end
    end else if (complete || have_pix) begin
      emit             = 1'b1;
      res.kind         = complete ? KIND_DONE : KIND_PIXEL;
      res.column       = 12'(pcol);
      res.row          = 12'(prow);
      res.pixel_bgra   = pval;
      res.image_width  = width[12:0];
      res.image_height = 13'(habs);
    end
  end

  assign res_valid = item_take && emit;

  always_ff @(posedge clk) begin
    if (rst || (item_take && item.end_of_file)) begin
      phase   <= PH_HEADER;
      pos     <= '0;
      pix_off <= '0;
      dib     <= '0;
      width   <= '0;
      height  <= '0;
      bpp     <= '0;
      comp    <= '0;
      col     <= '0;
      row     <= '0;
      habs    <= '0;
      bottom  <= 1'b0;
      bip     <= '0;
      gather  <= '0;
      pad     <= '0;
    end else if (item_take) begin
      phase   <= phase_next;
      pos     <= pos_next;
      pix_off <= pix_off_next;
      dib     <= dib_next;
      width   <= width_next;
      height  <= height_next;
      bpp     <= bpp_next;
      comp    <= comp_next;
      col     <= col_next;
      row     <= row_next;
      habs    <= habs_next;
      bottom  <= bottom_next;
      bip     <= bip_next;
      gather  <= gather_next;
      pad     <= pad_next;
    end
  end

endmodule

@@ src/bsd_out_stage.sv @@
// Output register stage: holds one result beat until the sink takes it.
module bsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  bsd_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output bsd_pkg::result_t out_res
);
  import bsd_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

@@ src/bmp_stream_decoder.sv @@
// BMP stream decoder for 24 and 32 bpp images, one file byte per beat.
// Takes one byte per cycle while the result side keeps up. A byte that gives a result has it
// in the output register once it is taken from the input register (input register, one pass
// of per-byte decode logic, output register). Every byte needs a free output register to move
// on, so a result held by the sink stalls the input.
// The header is captured little-endian and checked field by field; the first failing check
// gives a single error result, after which bytes are dropped until the end-of-file byte.
// Pixels come out in file order with their destination column and row (bottom-up files are
// flipped through the row index); the byte that ends the pixel data, padding included,
// gives the image-complete result. A byte marked end-of-file always returns the decoder
// to its reset state, so the next byte starts a new file.
module bmp_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  error_code,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic [31:0] pixel_bgra,
  output logic [12:0] image_width,
  output logic [12:0] image_height
);
  import bsd_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, item_take, res_valid, res_ready;

  assign in_item.byte_in     = byte_in;
  assign in_item.end_of_file = end_of_file;

  bsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  bsd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  bsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign error_code   = out_res.error_code;
  assign column       = out_res.column;
  assign row          = out_res.row;
  assign pixel_bgra   = out_res.pixel_bgra;
  assign image_width  = out_res.image_width;
  assign image_height = out_res.image_height;

endmodule

@@ src/bsd_checker.sv @@
// Port-level checks of the BMP stream decoder, bound to the top level.
`include "assert_macros.svh"

module bsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [2:0]  error_code,
  input logic [11:0] column,
  input logic [11:0] row,
  input logic [31:0] pixel_bgra,
  input logic [12:0] image_width,
  input logic [12:0] image_height
);
  import bsd_pkg::*;

  `ASSERT_SAME(a_err_fields, clk, rst, out_valid && kind == KIND_ERROR, error_code != ERR_NONE && column == 12'd0 && row == 12'd0 && pixel_bgra == 32'd0, "error beat with pixel fields set")
  `ASSERT_SAME(a_pix_code, clk, rst, out_valid && kind != KIND_ERROR, error_code == ERR_NONE && image_width != 13'd0 && image_height != 13'd0, "pixel or done beat without header size")
  `ASSERT_SAME(a_pix_bounds, clk, rst, out_valid && kind == KIND_PIXEL, {1'b0, column} < image_width && {1'b0, row} < image_height, "pixel outside image")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(kind) && $stable(error_code) && $stable(pixel_bgra), "stalled result beat changed")

endmodule

bind bmp_stream_decoder bsd_checker u_bsd_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for bmp_stream_decoder: header probes, random BMP files, idle and backpressure.
`timescale 1ns / 100ps

module testbench;
  import bsd_pkg::*;

  localparam logic [7:0] SIG_B = "B";
  localparam logic [7:0] SIG_M = "M";
  localparam int HDR_BYTES   = 54;
  localparam int N_FILES     = 5;
  localparam int HOLD_AT     = 10;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic [2:0] {
    DEC_HEADER, DEC_SKIP, DEC_PIXELS, DEC_PAD, DEC_DONE, DEC_ERROR
  } dec_state_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    logic [2:0] code;
    idle_mode_t idle;
  } file_beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    logic [2:0] code;
  } hdr_probe_t;

  // typed rows expect the given error code, or nothing when the code is ERR_NONE
  localparam hdr_probe_t HDR_PROBES [15] = '{
    {8'h58, 1'b0, 1'b1, ERR_SIG},
    {8'h00, 1'b1, 1'b1, ERR_NONE},
    {SIG_B, 1'b1, 1'b1, ERR_TRUNC},
    {SIG_B, 1'b0, 1'b1, ERR_NONE},
    {8'hFF, 1'b1, 1'b1, ERR_SIG},
    {8'hFF, 1'b0, 1'b1, ERR_SIG},
    {8'hFF, 1'b1, 1'b1, ERR_NONE},
    {8'h00, 1'b1, 1'b1, ERR_SIG},
    {SIG_B, 1'b0, 1'b1, ERR_NONE},
    {SIG_M, 1'b0, 1'b1, ERR_NONE},
    {8'h00, 1'b0, 1'b0, ERR_NONE},
    {8'hFF, 1'b1, 1'b1, ERR_TRUNC},
    {SIG_M, 1'b1, 1'b1, ERR_SIG},
    {SIG_B, 1'b0, 1'b1, ERR_NONE},
    {SIG_M, 1'b1, 1'b1, ERR_TRUNC}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [11:0] column;
  logic [11:0] row;
  logic [31:0] pixel_bgra;
  logic [12:0] image_width;
  logic [12:0] image_height;

  bmp_stream_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_in(byte_in), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .error_code(error_code), .column(column), .row(row),
    .pixel_bgra(pixel_bgra), .image_width(image_width), .image_height(image_height)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // decoder shadow state
  dec_state_t  dec_st = DEC_HEADER;
  logic [31:0] hdr_pos = '0, pix_off = '0, dib_len = '0, img_w = '0, img_h = '0, comp = '0;
  logic [15:0] bpp = '0;
  logic [12:0] col_cnt = '0, row_cnt = '0;
  logic [1:0]  px_byte = '0, pad_cnt = '0;
  logic [23:0] gather = '0;

  file_beat_t  file_feed [$];
  result_t     decoded_due [$];
  file_beat_t  cur_beat = '0;
  int          total_beats = 0, files_queued = 0, bytes_taken = 0, mismatch_count = 0;
  int          pixels_seen = 0, images_done = 0, errors_seen = 0, drained = 0, hold_left = 0;

  function automatic logic [31:0] height_mag();
    return img_h[31] ? 32'd0 - img_h : img_h;
  endfunction

  function automatic bit rows_flipped();
    return img_h != 0 && !img_h[31];
  endfunction

  function void clear_decoder();
    dec_st = DEC_HEADER;
    hdr_pos = '0; pix_off = '0; dib_len = '0; img_w = '0; img_h = '0; comp = '0; bpp = '0;
    col_cnt = '0; row_cnt = '0; px_byte = '0; pad_cnt = '0; gather = '0;
  endfunction

  function bit close_row();
    row_cnt = row_cnt + 13'd1;
    if (row_cnt >= height_mag()) begin
      dec_st = DEC_DONE;
      return 1'b1;
    end
    dec_st = DEC_PIXELS;
    return 1'b0;
  endfunction

  function automatic result_t pack_result(logic [1:0] k, logic [2:0] c, logic [11:0] x,
                                          logic [11:0] y, logic [31:0] p, bit dims);
    result_t r;
    r.kind = k;
    r.error_code = c;
    r.column = x;
    r.row = y;
    r.pixel_bgra = p;
    r.image_width = dims ? img_w[12:0] : 13'd0;
    r.image_height = dims ? 13'(height_mag()) : 13'd0;
    return r;
  endfunction

  // advance the shadow decoder by one file byte; returns 1 when a result is due
  function bit decode_byte(input logic [7:0] b, input logic eof, output result_t r);
    logic [2:0]  err;
    bit          pix_ready, img_done, active, emit;
    logic [11:0] pcol, prow;
    logic [31:0] pval, pad, p;
    logic [1:0]  last;
    err = ERR_NONE;
    pix_ready = 1'b0;
    img_done = 1'b0;
    pcol = '0;
    prow = '0;
    pval = '0;
    r = '0;
    active = dec_st != DEC_DONE && dec_st != DEC_ERROR;
    case (dec_st)
      DEC_HEADER: begin
        p = hdr_pos;
        if (p >= 10 && p <= 13) pix_off |= 32'(b) << (8 * (p - 10));
        if (p >= 14 && p <= 17) dib_len |= 32'(b) << (8 * (p - 14));
        if (p >= 18 && p <= 21) img_w |= 32'(b) << (8 * (p - 18));
        if (p >= 22 && p <= 25) img_h |= 32'(b) << (8 * (p - 22));
        if (p >= 28 && p <= 29) bpp |= 16'(b) << (8 * (p - 28));
        if (p >= 30 && p <= 33) comp |= 32'(b) << (8 * (p - 30));
        if (p == 0 && b != SIG_B) err = ERR_SIG;
        if (p == 1 && b != SIG_M) err = ERR_SIG;
        if (p == 17 && dib_len != 40 && dib_len != 108 && dib_len != 124) err = ERR_DIB;
        if (p == 21 && (img_w == 0 || img_w > MAX_DIM)) err = ERR_WIDTH;
        if (p == 25 && (height_mag() == 0 || height_mag() > MAX_DIM)) err = ERR_HEIGHT;
        if (p == 33 && ((bpp != 24 && bpp != 32) || (comp != 0 && comp != 3))) err = ERR_FORMAT;
        if (p == 53 && pix_off < HDR_BYTES) err = ERR_OFFSET;
        hdr_pos = p + 1;
        if (p == 53 && err == ERR_NONE) dec_st = (pix_off == HDR_BYTES) ? DEC_PIXELS : DEC_SKIP;
      end
      DEC_SKIP: begin
        hdr_pos = hdr_pos + 1;
        if (hdr_pos >= pix_off) dec_st = DEC_PIXELS;
      end
      DEC_PIXELS: begin
        last = (bpp == 32) ? 2'd3 : 2'd2;
        if (px_byte < last) begin
          gather = gather | (24'(b) << (8 * px_byte));
          px_byte = px_byte + 2'd1;
        end else begin
          pval = (last == 2'd3) ? {b, gather} : {8'hFF, b, gather[15:0]};
          pcol = col_cnt[11:0];
          prow = rows_flipped() ? 12'(height_mag() - 1 - row_cnt) : row_cnt[11:0];
          pix_ready = 1'b1;
          px_byte = '0;
          gather = '0;
          col_cnt = col_cnt + 13'd1;
          if (col_cnt >= img_w) begin
            pad = (4 - ((img_w * (last + 1)) & 3)) & 3;
            col_cnt = '0;
            if (pad != 0) begin
              pad_cnt = pad[1:0];
              dec_st = DEC_PAD;
            end else begin
              img_done = close_row();
            end
          end
        end
      end
      DEC_PAD: begin
        pad_cnt = pad_cnt - 2'd1;
        if (pad_cnt == 0) img_done = close_row();
      end
      default: ;
    endcase
    emit = 1'b1;
    if (err != ERR_NONE) begin
      r = pack_result(KIND_ERROR, err, '0, '0, '0, 1'b0);
      dec_st = DEC_ERROR;
    end else if (eof && active && !img_done) begin
      r = pack_result(KIND_ERROR, ERR_TRUNC, '0, '0, '0, dec_st != DEC_HEADER);
    end else if (img_done) begin
      r = pack_result(KIND_DONE, ERR_NONE, pcol, prow, pval, 1'b1);
    end else if (pix_ready) begin
      r = pack_result(KIND_PIXEL, ERR_NONE, pcol, prow, pval, 1'b1);
    end else begin
      emit = 1'b0;
    end
    if (eof) clear_decoder();
    return emit;
  endfunction

  function automatic bit sender_idles(idle_mode_t m);
    return (m == IDLE_SEND && $urandom_range(0, 99) < 54) ||
           (m == IDLE_BOTH && $urandom_range(0, 99) < 8);
  endfunction

  function automatic bit receiver_stalls(idle_mode_t m);
    return (m == IDLE_RECV && $urandom_range(0, 99) < 54) ||
           (m == IDLE_BOTH && $urandom_range(0, 99) < 8);
  endfunction

  task automatic push_beat(logic [7:0] b, logic eof, logic typed, logic [2:0] code,
                           idle_mode_t m);
    file_beat_t fb;
    fb.b = b;
    fb.eof = eof;
    fb.typed = typed;
    fb.code = code;
    fb.idle = m;
    file_feed.push_back(fb);
    if (eof) files_queued++;
  endtask

  task automatic queue_file(logic [31:0] w, logic [31:0] h, logic [31:0] off,
                            logic [31:0] dib, logic [31:0] comp_v, logic [15:0] bits,
                            bit sig_bad, int unsigned trim, int unsigned keep_max,
                            int unsigned extra, idle_mode_t m);
    logic [7:0]  img [$];
    logic [31:0] mag, skip_len;
    int unsigned bpb, pad, k;
    bit          hdr_ok;
    img.push_back(SIG_B);
    img.push_back(SIG_M);
    repeat (8) img.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) img.push_back(off[8*i +: 8]);
    for (int i = 0; i < 4; i++) img.push_back(dib[8*i +: 8]);
    for (int i = 0; i < 4; i++) img.push_back(w[8*i +: 8]);
    for (int i = 0; i < 4; i++) img.push_back(h[8*i +: 8]);
    repeat (2) img.push_back(8'($urandom));
    for (int i = 0; i < 2; i++) img.push_back(bits[8*i +: 8]);
    for (int i = 0; i < 4; i++) img.push_back(comp_v[8*i +: 8]);
    repeat (20) img.push_back(8'($urandom));
    if (sig_bad) begin
      k = $urandom_range(0, 1);
      img[k] = img[k] ^ 8'($urandom_range(1, 255));
    end
    mag = h[31] ? 32'd0 - h : h;
    hdr_ok = !sig_bad && (dib == 40 || dib == 108 || dib == 124) && w != 0 && w <= MAX_DIM &&
             mag != 0 && mag <= MAX_DIM && (bits == 24 || bits == 32) &&
             (comp_v == 0 || comp_v == 3) && off >= HDR_BYTES;
    skip_len = off - HDR_BYTES;
    if (hdr_ok && skip_len <= 64) begin
      repeat (skip_len) img.push_back(8'($urandom));
      bpb = (bits == 32) ? 4 : 3;
      pad = (4 - (w * bpb) % 4) % 4;
      repeat (mag * (w * bpb + pad)) img.push_back(8'($urandom));
    end else if (hdr_ok) begin
      repeat (10) img.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 10)) img.push_back(8'($urandom));
    end
    while (trim != 0 && img.size() > 1) begin
      void'(img.pop_back());
      trim--;
    end
    while (keep_max != 0 && img.size() > keep_max) void'(img.pop_back());
    repeat (extra) img.push_back(8'($urandom));
    foreach (img[i]) push_beat(img[i], i == img.size() - 1, 1'b0, ERR_NONE, m);
  endtask

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (file_feed.size() != 0 && !sender_idles(file_feed[0].idle)) begin
        cur_beat <= file_feed[0];
        byte_in <= file_feed[0].b;
        end_of_file <= file_feed[0].eof;
        in_valid <= 1'b1;
        void'(file_feed.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver; one long hold-off once enough beats have drained
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) drained <= drained + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && drained == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_stalls(cur_beat.idle);
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want, got;
    bit      due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        due = decode_byte(byte_in, end_of_file, want);
        if (cur_beat.typed) begin
          if (cur_beat.code != ERR_NONE)
            decoded_due.push_back(pack_result(KIND_ERROR, cur_beat.code, '0, '0, '0, 1'b0));
        end else if (due) begin
          decoded_due.push_back(want);
        end
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got = {kind, error_code, column, row, pixel_bgra, image_width, image_height};
        if (got.kind == KIND_PIXEL) pixels_seen++;
        else if (got.kind == KIND_DONE) images_done++;
        else errors_seen++;
        if (decoded_due.size() == 0) begin
          note_failure($sformatf("unexpected beat: kind %0d code %0d x %0d y %0d bgra %08h",
                                 got.kind, got.error_code, got.column, got.row,
                                 got.pixel_bgra));
        end else begin
          want = decoded_due.pop_front();
          if (got.kind !== want.kind || got.error_code !== want.error_code ||
              got.column !== want.column || got.row !== want.row ||
              got.pixel_bgra !== want.pixel_bgra || got.image_width !== want.image_width ||
              got.image_height !== want.image_height)
            note_failure($sformatf({"mismatch: exp kind %0d code %0d x %0d y %0d bgra %08h ",
                                    "w %0d h %0d / got kind %0d code %0d x %0d y %0d ",
                                    "bgra %08h w %0d h %0d"},
                                   want.kind, want.error_code, want.column, want.row,
                                   want.pixel_bgra, want.image_width, want.image_height,
                                   got.kind, got.error_code, got.column, got.row,
                                   got.pixel_bgra, got.image_width, got.image_height));
        end
      end
    end
  end

  initial begin
    int unsigned roll, trim, keep_max, extra, n_noise;
    logic [31:0] w, h, off, dib, comp_v;
    logic [15:0] bits;
    bit          sig_bad;
    idle_mode_t  m;

    foreach (HDR_PROBES[i])
      push_beat(HDR_PROBES[i].b, HDR_PROBES[i].eof, HDR_PROBES[i].typed, HDR_PROBES[i].code,
                IDLE_NONE);

    for (int f = 0; f < N_FILES; f++) begin
      m = idle_mode_t'(f % 4);
      roll = $urandom_range(0, 99);
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 2);
      if ($urandom_range(0, 1)) h = 32'd0 - h;
      bits = $urandom_range(0, 1) ? 16'd32 : 16'd24;
      comp_v = $urandom_range(0, 1) ? 32'd3 : 32'd0;
      case ($urandom_range(0, 2))
        0: dib = 40;
        1: dib = 108;
        default: dib = 124;
      endcase
      off = $urandom_range(0, 1) ? 32'd54 : 32'd54 + $urandom_range(1, 6);
      sig_bad = 1'b0;
      trim = 0;
      keep_max = 0;
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (roll < 20) begin
        trim = $urandom_range(1, 12);
      end else if (roll >= 70 && roll < 95) begin
        case ($urandom_range(0, 8))
          0: sig_bad = 1'b1;
          1: case ($urandom_range(0, 3))
               0: dib = 0;
               1: dib = 41;
               2: dib = 32'hFFFF_FFFF;
               default: dib = $urandom;
             endcase
          2: case ($urandom_range(0, 2))
               0: w = 0;
               1: w = MAX_DIM + 1;
               default: w = 32'hFFFF_FFFF;
             endcase
          3: case ($urandom_range(0, 3))
               0: h = 0;
               1: h = MAX_DIM + 1;
               2: h = 32'd0 - (MAX_DIM + 1);
               default: h = 32'h8000_0000;
             endcase
          4: case ($urandom_range(0, 3))
               0: bits = 16'd0;
               1: bits = 16'd8;
               2: bits = 16'd16;
               default: bits = 16'hFFFF;
             endcase
          5: case ($urandom_range(0, 2))
               0: comp_v = 1;
               1: comp_v = 2;
               default: comp_v = 32'hFFFF_FFFF;
             endcase
          6: off = $urandom_range(0, 53);
          7: off = $urandom | 32'h0100_0000;
          default: keep_max = $urandom_range(3, 60);
        endcase
      end
      if (roll >= 95) begin
        n_noise = $urandom_range(1, 40);
        for (int i = 0; i < n_noise; i++)
          push_beat(8'($urandom), i == n_noise - 1, 1'b0, ERR_NONE, m);
      end else begin
        queue_file(w, h, off, dib, comp_v, bits, sig_bad, trim, keep_max, extra, m);
      end
      // widest and tallest headers, each cut short just after its first pixel
      if (f == N_FILES / 2) begin
        queue_file(MAX_DIM, 1, 54, 40, 0, 16'd24, 1'b0, 0, 58, 0, IDLE_NONE);
        queue_file(1, 32'd0 - MAX_DIM, 54, 124, 3, 16'd32, 1'b0, 0, 60, 0, IDLE_BOTH);
      end
    end
    total_beats = file_feed.size();

    while (bytes_taken != total_beats) @(posedge clk);
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("fed %0d bytes over %0d files; got %0d pixels, %0d images done, %0d errors",
             bytes_taken, files_queued, pixels_seen, images_done, errors_seen);
    $display("idle modes rotated per file, one %0d-cycle receiver hold; %0d mismatches",
             HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
